// ===== rtl/sdms_pkg.sv =====
// ----------------------------------------------------------------------------
// SD multi-block session sequencer package
// Request and action beat types, action and mode codes, block geometry.
// ----------------------------------------------------------------------------
package sdms_pkg;

    // Block geometry: a power of two, so divide is a shift and remainder a mask
    localparam int BLOCK_BYTES = 512;
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WR    = 2'd1,
        OP_ERASE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ACT_STOP_READ   = 4'd0,
        ACT_STOP_WRITE  = 4'd1,
        ACT_START_READ  = 4'd2,
        ACT_START_WRITE = 4'd3,
        ACT_READ_BLK    = 4'd4,
        ACT_WRITE_BLK   = 4'd5,
        ACT_ERASE_START = 4'd6,
        ACT_ERASE_END   = 4'd7,
        ACT_ERASE       = 4'd8
    } act_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] page;
        logic [31:0] last_page;
        logic [23:0] byte_count;
    } req_t;

    typedef struct packed {
        logic [3:0]  action;
        logic [31:0] argument;
        logic [15:0] block_count;
        logic [9:0]  tail_bytes;
        logic        last;
    } act_beat_t;

endpackage

// ===== rtl/sd_multiblock_session_sequencer.sv =====
// ----------------------------------------------------------------------------
// SD multi-block session sequencer
// Turns read, write and erase requests into card session actions.
// ----------------------------------------------------------------------------
//  channel  | ports                      | beat
//  ---------+----------------------------+--------------------------------
//  request  | s_valid, s_ready, s_data   | op, page, last_page, byte_count
//  action   | m_valid, m_ready, m_data   | action, argument, block_count,
//           |                            | tail_bytes, last
//
// A request is planned in the cycle it is accepted: session state updates at
// once and its one to four actions go into a plan register. The plan feeds
// the output register one action per cycle unless m_ready low stalls it.
// The next request is accepted in the cycle the last action of the plan moves
// into the output register. An unknown op is accepted with no beat.
// m_ready low with a valid beat holds the output register and, behind it, the plan.
// Reset (aresetn low at a clock edge) sets the mode idle and next page zero.
// ----------------------------------------------------------------------------
module sd_multiblock_session_sequencer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sdms_pkg::req_t     s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sdms_pkg::act_beat_t m_data
);
    import sdms_pkg::*;

    // session state
    mode_t       mode_reg;
    mode_t       mode_next;
    logic [31:0] next_page_reg;
    logic [31:0] next_page_next;

    // plan of pending actions
    logic        pl_valid_reg;
    logic [2:0]  pl_cnt_reg;
    logic [1:0]  pl_idx_reg;
    act_t        pl_acts_reg [4];
    logic [31:0] pl_page_reg;
    logic [31:0] pl_end_reg;
    logic [15:0] pl_blocks_reg;
    logic [9:0]  pl_tail_reg;

    act_t        plan_acts [4];
    logic [2:0]  plan_cnt;

    // output register
    logic        m_valid_reg;
    act_beat_t   m_data_reg;
    act_beat_t   m_data_next;

    logic        s_accept;
    logic        emit;
    logic        pl_last;
    act_t        cur_act;

    // transfer geometry
    logic        bytes_nz;
    logic [24:0] bytes_round;
    logic [23:0] bytes_m1;
    logic [15:0] xfer_blocks;
    logic [9:0]  xfer_tail;
    logic        need_stop;
    act_t        stop_act;
    logic        cont;

    assign emit     = pl_valid_reg && (!m_valid_reg || m_ready);
    assign pl_last  = ({1'b0, pl_idx_reg} + 3'd1) == pl_cnt_reg;
    assign s_ready  = !pl_valid_reg || (emit && pl_last);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign cur_act  = pl_acts_reg[pl_idx_reg];

    assign bytes_nz    = |s_data.byte_count;
    assign bytes_round = {1'b0, s_data.byte_count} + 25'(BLOCK_BYTES - 1);
    assign bytes_m1    = s_data.byte_count - 24'd1;
    assign xfer_blocks = bytes_nz ? 16'(bytes_round >> BLOCK_SHIFT) : 16'd1;
    assign xfer_tail   = bytes_nz ? 10'(bytes_m1[BLOCK_SHIFT-1:0]) + 10'd1 : 10'd0;

    assign need_stop = (mode_reg == MODE_READ) || (mode_reg == MODE_WRITE);
    assign stop_act  = (mode_reg == MODE_WRITE) ? ACT_STOP_WRITE : ACT_STOP_READ;

    // plan the actions of the incoming request and the state it leaves
    always_comb begin
        plan_acts      = '{default: ACT_ERASE};
        plan_cnt       = 3'd0;
        mode_next      = mode_reg;
        next_page_next = next_page_reg;
        cont           = 1'b0;
        unique case (s_data.op)
            OP_READ, OP_WR: begin
                cont = (s_data.page == next_page_reg) &&
                       (((s_data.op == OP_READ) && (mode_reg == MODE_READ)) ||
                        ((s_data.op == OP_WR) && (mode_reg == MODE_WRITE)));
                if (!cont) begin
                    if (need_stop) begin
                        plan_acts[plan_cnt[1:0]] = stop_act;
                        plan_cnt = plan_cnt + 3'd1;
                    end
                    plan_acts[plan_cnt[1:0]] = (s_data.op == OP_READ) ?
                                               ACT_START_READ : ACT_START_WRITE;
                    plan_cnt = plan_cnt + 3'd1;
                end
                plan_acts[plan_cnt[1:0]] = (s_data.op == OP_READ) ?
                                           ACT_READ_BLK : ACT_WRITE_BLK;
                plan_cnt  = plan_cnt + 3'd1;
                mode_next = (s_data.op == OP_READ) ? MODE_READ : MODE_WRITE;
                next_page_next = (cont ? next_page_reg : s_data.page) +
                                 32'(xfer_blocks);
            end
            OP_ERASE: begin
                if (need_stop) begin
                    plan_acts[plan_cnt[1:0]] = stop_act;
                    plan_cnt = plan_cnt + 3'd1;
                end
                plan_acts[plan_cnt[1:0]] = ACT_ERASE_START;
                plan_acts[plan_cnt[1:0] + 2'd1] = ACT_ERASE_END;
                plan_acts[plan_cnt[1:0] + 2'd2] = ACT_ERASE;
                plan_cnt  = plan_cnt + 3'd3;
                mode_next = MODE_IDLE;
            end
            default: begin
                // unknown op: drop without effect
            end
        endcase
    end

    // build the next output beat from the current plan entry
    always_comb begin
        m_data_next             = '0;
        m_data_next.action      = cur_act;
        m_data_next.last        = pl_last;
        case (cur_act)
            ACT_START_READ, ACT_START_WRITE, ACT_ERASE_START: begin
                m_data_next.argument = pl_page_reg;
            end
            ACT_READ_BLK, ACT_WRITE_BLK: begin
                m_data_next.argument    = pl_page_reg;
                m_data_next.block_count = pl_blocks_reg;
                m_data_next.tail_bytes  = pl_tail_reg;
            end
            ACT_ERASE_END: begin
                m_data_next.argument = pl_end_reg;
            end
            default: begin
                m_data_next.argument = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            next_page_reg <= '0;
            pl_valid_reg  <= 1'b0;
            pl_cnt_reg    <= '0;
            pl_idx_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_accept) begin
                mode_reg      <= mode_next;
                next_page_reg <= next_page_next;
                pl_valid_reg  <= plan_cnt != 3'd0;
                pl_cnt_reg    <= plan_cnt;
                pl_idx_reg    <= '0;
            end else if (emit) begin
                // advance through the plan; drop it after its last beat
                if (pl_last) begin
                    pl_valid_reg <= 1'b0;
                end else begin
                    pl_idx_reg <= pl_idx_reg + 2'd1;
                end
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pl_acts_reg   <= plan_acts;
            pl_page_reg   <= s_data.page;
            pl_end_reg    <= s_data.last_page;
            pl_blocks_reg <= xfer_blocks;
            pl_tail_reg   <= xfer_tail;
        end
        if (emit) begin
            m_data_reg <= m_data_next;
        end
    end

    a_plan_index: assert property (@(posedge aclk) disable iff (!aresetn)
        pl_valid_reg |-> (pl_cnt_reg != 3'd0) && ({1'b0, pl_idx_reg} < pl_cnt_reg))
        else $error("plan index outside the planned action count");

    a_xfer_geometry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && ((m_data_reg.action == ACT_READ_BLK) ||
                        (m_data_reg.action == ACT_WRITE_BLK))
        |-> (m_data_reg.block_count != 16'd0) &&
            (m_data_reg.tail_bytes <= 10'(BLOCK_BYTES)))
        else $error("transfer beat with bad block count or tail");

    a_erase_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_data.op == OP_ERASE) |=> (mode_reg == MODE_IDLE))
        else $error("session left open after erase");

endmodule

// ===== bench/sd_multiblock_session_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// SD multi-block session sequencer testbench
// Drives read, write, erase and unknown requests with random gaps and output
// stalls, predicts the session actions of each accepted request, and checks
// every action beat field by field against the oldest predicted action.
// ----------------------------------------------------------------------------
module sd_multiblock_session_sequencer_tb;
    import sdms_pkg::*;

    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam int MAX_GAP = 14;
    localparam int SETTLE_CYCLES = 8;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    req_t      s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    act_beat_t m_data;

    // predicted card session state
    mode_t       card_mode = MODE_IDLE;
    logic [31:0] card_next_page = '0;

    act_beat_t pending_actions[$];
    act_beat_t planned[$];
    int        action_errors = 0;
    bit        send_idle_en = 1'b1;
    bit        sink_idle_en = 1'b1;

    sd_multiblock_session_sequencer uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic act_beat_t make_action(act_t act, logic [31:0] arg,
                                              logic [15:0] blocks,
                                              logic [9:0] tail);
        act_beat_t b;
        b.action      = act;
        b.argument    = arg;
        b.block_count = blocks;
        b.tail_bytes  = tail;
        b.last        = 1'b0;
        return b;
    endfunction

    function automatic void close_open_session();
        if (card_mode == MODE_WRITE)
            planned.push_back(make_action(ACT_STOP_WRITE, '0, '0, '0));
        else if (card_mode == MODE_READ)
            planned.push_back(make_action(ACT_STOP_READ, '0, '0, '0));
        card_mode = MODE_IDLE;
    endfunction

    function automatic void plan_session_actions(req_t r);
        int unsigned blocks;
        int unsigned tail;
        logic        rd;
        mode_t       want;
        planned.delete();
        rd = (r.op == OP_READ);
        want = rd ? MODE_READ : MODE_WRITE;
        if (r.op == OP_ERASE) begin
            close_open_session();
            planned.push_back(make_action(ACT_ERASE_START, r.page, '0, '0));
            planned.push_back(make_action(ACT_ERASE_END, r.last_page, '0, '0));
            planned.push_back(make_action(ACT_ERASE, '0, '0, '0));
        end else if (r.op == OP_READ || r.op == OP_WR) begin
            if (card_mode != want || r.page != card_next_page) begin
                close_open_session();
                planned.push_back(make_action(rd ? ACT_START_READ : ACT_START_WRITE,
                                              r.page, '0, '0));
                card_mode = want;
                card_next_page = r.page;
            end
            if (r.byte_count == 0) begin
                blocks = 1;
                tail = 0;
            end else begin
                blocks = (r.byte_count + BLOCK_BYTES - 1) / BLOCK_BYTES;
                tail = r.byte_count - (blocks - 1) * BLOCK_BYTES;
            end
            planned.push_back(make_action(rd ? ACT_READ_BLK : ACT_WRITE_BLK, r.page,
                                          blocks[15:0], tail[9:0]));
            card_next_page = card_next_page + blocks;
        end
        if (planned.size() > 0)
            planned[planned.size() - 1].last = 1'b1;
        foreach (planned[i])
            pending_actions.push_back(planned[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver and action sink
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [1:0] op, input logic [31:0] page,
                                input logic [31:0] last_page,
                                input logic [23:0] byte_count);
        req_t r;
        int   gap;
        r.op         = op;
        r.page       = page;
        r.last_page  = last_page;
        r.byte_count = byte_count;
        gap = send_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        plan_session_actions(r);
    endtask

    task automatic wait_for_actions_drained();
        s_valid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge aclk);
        // an unknown op leaves no beat behind, so give the block time to finish
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_byte_count();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) return 24'($urandom_range(0, 2048));
        if (pick < 9) return 24'($urandom_range(0, 65535));
        return 24'($urandom);
    endfunction

    task automatic send_random_request();
        int          pick;
        logic [1:0]  op;
        logic [31:0] page;
        pick = $urandom_range(0, 99);
        page = ($urandom_range(0, 3) == 0) ? (32'hFFFF_FFFF - $urandom_range(0, 64))
                                           : $urandom;
        if (pick < 55 && card_mode != MODE_IDLE) begin
            // continue the open session with random length
            op = (card_mode == MODE_READ) ? OP_READ : OP_WR;
            send_request(op, card_next_page, $urandom, rand_byte_count());
        end else if (pick < 75) begin
            send_request(2'($urandom_range(0, 1)), page, $urandom, rand_byte_count());
        end else if (pick < 87) begin
            send_request(OP_ERASE, page, $urandom, 24'($urandom));
        end else if (pick < 92) begin
            send_request(OP_UNKNOWN, $urandom, $urandom, 24'($urandom));
        end else begin
            // right page, possibly the wrong kind
            send_request(2'($urandom_range(0, 3)), card_next_page, $urandom,
                         24'($urandom));
        end
    endtask

    initial begin
        int stall;
        forever begin
            stall = sink_idle_en ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // ------------------------------------------------------------------------
    // Action checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        act_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_actions.size() == 0) begin
                action_errors++;
                if (action_errors <= 10)
                    $display("unexpected action beat: act=%0d arg=%h blk=%0d tail=%0d last=%b",
                             m_data.action, m_data.argument, m_data.block_count,
                             m_data.tail_bytes, m_data.last);
            end else begin
                want = pending_actions.pop_front();
                if (m_data.action !== want.action || m_data.argument !== want.argument
                    || m_data.block_count !== want.block_count
                    || m_data.tail_bytes !== want.tail_bytes
                    || m_data.last !== want.last) begin
                    action_errors++;
                    if (action_errors <= 10)
                        $display({"action mismatch: exp act=%0d arg=%h blk=%0d tail=%0d ",
                                  "last=%b, got act=%0d arg=%h blk=%0d tail=%0d last=%b"},
                                 want.action, want.argument, want.block_count,
                                 want.tail_bytes, want.last, m_data.action,
                                 m_data.argument, m_data.block_count,
                                 m_data.tail_bytes, m_data.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_sessions();
        send_request(OP_READ, 32'd100, '0, 24'd1024);
        send_request(OP_READ, card_next_page, '0, 24'd1);
        // zero length still moves one block
        send_request(OP_READ, card_next_page, '0, 24'd0);
        send_request(OP_READ, 32'd200, '0, 24'd513);
        send_request(OP_WR, card_next_page, '0, 24'hFF_FFFF);
        send_request(OP_WR, card_next_page, '0, 24'd512);
        // erase with a write session open: the longest plan
        send_request(OP_ERASE, 32'd0, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_request(OP_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_request(OP_ERASE, 32'hFFFF_FFFF, 32'd0, 24'd0);
        // erase leaves next page alone but the mode idle
        send_request(OP_READ, card_next_page, '0, 24'd511);
        // wrap the page counter
        send_request(OP_READ, 32'hFFFF_FFFF, '0, 24'd1024);
        send_request(OP_READ, card_next_page, '0, 24'hFF_FFFF);
        send_request(OP_ERASE, 32'h5555_AAAA, 32'hAAAA_5555, 24'd7);
        send_request(OP_WR, 32'd0, '0, 24'd0);
        send_request(OP_WR, card_next_page, '0, 24'd1);
        // unknown op between transfers must not break the session
        send_request(OP_UNKNOWN, '0, '0, '0);
        send_request(OP_WR, card_next_page, '0, 24'd1536);
        send_request(OP_READ, card_next_page, '0, 24'd2);
        send_request(OP_WR, card_next_page, '0, 24'd3);
        send_request(OP_WR, card_next_page + 32'd1, '0, 24'd4);
        wait_for_actions_drained();
    endtask

    task automatic test_random_sessions();
        send_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        repeat (60) send_random_request();
    endtask

    task automatic test_back_to_back();
        send_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        repeat (20) send_random_request();
    endtask

    task automatic test_drain_pause();
        send_idle_en = 1'b0;
        sink_idle_en = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_random_request();
            if (i % 3 == 2)
                wait_for_actions_drained();
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_sessions();
        test_random_sessions();
        test_back_to_back();
        test_drain_pause();
        wait_for_actions_drained();
        if (action_errors == 0 && pending_actions.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sdms_pkg.sv
rtl/sd_multiblock_session_sequencer.sv
bench/sd_multiblock_session_sequencer_tb.sv
